// ===== sv/cfwa_pkg.sv =====
// ----------------------------------------------------------------------------
// cfwa_pkg
// shared widths, codes and defaults of the wave assigner
// ----------------------------------------------------------------------------
package cfwa_pkg;

    localparam int MOLECULES_DEF = 4096;
    localparam int COMPLEXES_DEF = 4096;
    localparam int WAVE_BITS_DEF = 16;

    // beat field widths
    localparam int MOL_IDX_W = 12;
    localparam int CPLX_W    = 13;
    localparam int MFLAG_W   = 5;
    localparam int CFLAG_W   = 2;

    // configuration port
    localparam int COUNT_W   = 13;
    localparam int CFG_IDX_W = 1;

    // batch tag stored with every table entry
    localparam int EPOCH_BITS = 8;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_PAIR  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MOL_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CPLX_COUNT = 1'b1;

    // molecule flag bits
    localparam int MF_EMPTY    = 0;
    localparam int MF_LIPID    = 1;
    localparam int MF_GHOST    = 2;
    localparam int MF_BONDS    = 3;
    localparam int MF_EXCL_VOL = 4;

    // complex flag bits
    localparam int CF_FIBER   = 0;
    localparam int CF_SURFACE = 1;

endpackage

// ===== sv/cfwa_ram.sv =====
// ----------------------------------------------------------------------------
// cfwa_ram
// simple dual read, single write ram with registered read data
// ----------------------------------------------------------------------------
module cfwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr0,
    input  logic [AW-1:0]    i_raddr1,
    output logic [WIDTH-1:0] o_rdata0,
    output logic [WIDTH-1:0] o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

// ===== sv/conflict_free_wave_assigner_core.sv =====
// ----------------------------------------------------------------------------
// conflict_free_wave_assigner_core
// levelizes pair beats into conflict free waves using molecule and complex
// wave tables held in block ram
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | input     | i_in_valid/o_in_stall| opcode, molecules, complexes, flags
//  out     | output    | o_out_valid/i_out_stall | wave number, serialized, saturated
//  cfg     | input     | i_cfg_we             | i_cfg_idx, i_cfg_data
//
//  a pair beat steps through table read, wave max, write of the a side and
//  write of the b side; both tables have a single write port, so sides go in turn
//  a clear beat skips to the b side write state; every 255th clear adds a tag sweep
//  after reset, and on tag wrap, every entry up to max(MOLECULES,
//  COMPLEXES) is swept with the input stalled; cfg writes are taken throughout
//  a waiting result holds in the output register; the next beat is accepted
//  meanwhile and finishes once the output register frees up
//
module conflict_free_wave_assigner_core
    import cfwa_pkg::*;
#(
    parameter int MOLECULES = MOLECULES_DEF,
    parameter int COMPLEXES = COMPLEXES_DEF,
    parameter int WAVE_BITS = WAVE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [COUNT_W-1:0]     i_cfg_data,
    // input beats
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_opcode,
    input  logic [MOL_IDX_W-1:0]   i_mol_a,
    input  logic [MOL_IDX_W-1:0]   i_mol_b,
    input  logic signed [CPLX_W-1:0] i_cplx_a,
    input  logic signed [CPLX_W-1:0] i_cplx_b,
    input  logic [MFLAG_W-1:0]     i_mol_a_flags,
    input  logic [MFLAG_W-1:0]     i_mol_b_flags,
    input  logic [CFLAG_W-1:0]     i_cplx_a_flags,
    input  logic [CFLAG_W-1:0]     i_cplx_b_flags,
    // result beats
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [WAVE_BITS-1:0]   o_wave_number,
    output logic                   o_serialized,
    output logic                   o_saturated
);

    // table address widths and widths for index range checks
    localparam int MA_W    = (MOLECULES > 1) ? $clog2(MOLECULES) : 1;
    localparam int CA_W    = (COMPLEXES > 1) ? $clog2(COMPLEXES) : 1;
    localparam int MCMP_W  = ((MA_W > MOL_IDX_W) ? MA_W : MOL_IDX_W) + 1;
    localparam int CCMP_W  = ((CA_W > CPLX_W - 1) ? CA_W : CPLX_W - 1) + 1;
    localparam int SWEEP_N = (MOLECULES > COMPLEXES) ? MOLECULES : COMPLEXES;
    localparam int SW_W    = (SWEEP_N > 1) ? $clog2(SWEEP_N) : 1;
    localparam int ENT_W   = EPOCH_BITS + WAVE_BITS;

    localparam logic [EPOCH_BITS-1:0] EPOCH_STALE = '0;
    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_CALC,
        S_WR_A,
        S_WR_B
    } t_state;

    t_state r_state;

    logic [COUNT_W-1:0]   r_mol_count;
    logic [COUNT_W-1:0]   r_cplx_count;
    logic [EPOCH_BITS-1:0] r_epoch;
    logic [SW_W-1:0]      r_sweep_cnt;

    // captured beat
    logic                 r_is_clear;
    logic                 r_ma_ok, r_mb_ok, r_ca_ok, r_cb_ok, r_unsafe;
    logic [MA_W-1:0]      r_ma_addr, r_mb_addr;
    logic [CA_W-1:0]      r_ca_addr, r_cb_addr;
    logic [WAVE_BITS-1:0] r_wave;

    logic [WAVE_BITS-1:0] r_serial_wave;
    logic                 r_serial_valid;

    logic                 r_out_valid;
    logic [WAVE_BITS-1:0] r_out_wave;
    logic                 r_out_serial;

    // ---------------------------------------------------------------- decode
    logic [MCMP_W-1:0] mol_a_w, mol_b_w;
    logic [CCMP_W-1:0] cplx_a_w, cplx_b_w;
    logic              ma_ok, mb_ok, ca_ok, cb_ok, unsafe;
    logic              in_accept, out_free;

    assign mol_a_w  = MCMP_W'(i_mol_a);
    assign mol_b_w  = MCMP_W'(i_mol_b);
    assign cplx_a_w = CCMP_W'(i_cplx_a[CPLX_W-2:0]);
    assign cplx_b_w = CCMP_W'(i_cplx_b[CPLX_W-2:0]);

    assign ma_ok = (mol_a_w < MCMP_W'(r_mol_count)) && (mol_a_w < MCMP_W'(MOLECULES));
    assign mb_ok = (mol_b_w < MCMP_W'(r_mol_count)) && (mol_b_w < MCMP_W'(MOLECULES));
    // a set sign bit means no complex
    assign ca_ok = !i_cplx_a[CPLX_W-1] && (cplx_a_w < CCMP_W'(r_cplx_count))
                   && (cplx_a_w < CCMP_W'(COMPLEXES));
    assign cb_ok = !i_cplx_b[CPLX_W-1] && (cplx_b_w < CCMP_W'(r_cplx_count))
                   && (cplx_b_w < CCMP_W'(COMPLEXES));

    assign unsafe = !ma_ok || !mb_ok
        || i_mol_a_flags[MF_EMPTY] || i_mol_a_flags[MF_LIPID] || i_mol_a_flags[MF_GHOST]
        || i_mol_b_flags[MF_EMPTY] || i_mol_b_flags[MF_LIPID] || i_mol_b_flags[MF_GHOST]
        || !ca_ok || !cb_ok || (i_cplx_a == i_cplx_b)
        || (i_cplx_a_flags[CF_FIBER] && i_cplx_b_flags[CF_FIBER])
        || (i_cplx_a_flags[CF_SURFACE] && i_cplx_b_flags[CF_SURFACE])
        || (i_mol_a_flags[MF_BONDS] && i_mol_a_flags[MF_EXCL_VOL])
        || (i_mol_b_flags[MF_BONDS] && i_mol_b_flags[MF_EXCL_VOL]);

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // ---------------------------------------------------------------- tables
    logic              mol_we, cplx_we;
    logic [MA_W-1:0]   mol_waddr;
    logic [CA_W-1:0]   cplx_waddr;
    logic [ENT_W-1:0]  tbl_wdata;
    logic [ENT_W-1:0]  mol_rd_a, mol_rd_b, cplx_rd_a, cplx_rd_b;

    always_comb begin
        mol_we     = 1'b0;
        cplx_we    = 1'b0;
        mol_waddr  = r_ma_addr;
        cplx_waddr = r_ca_addr;
        tbl_wdata  = {r_epoch, r_wave};
        case (r_state)
            S_SWEEP: begin
                // stale tag marks every entry as unwritten
                mol_we     = ({1'b0, r_sweep_cnt} < (SW_W + 1)'(MOLECULES));
                cplx_we    = ({1'b0, r_sweep_cnt} < (SW_W + 1)'(COMPLEXES));
                mol_waddr  = r_sweep_cnt[MA_W-1:0];
                cplx_waddr = r_sweep_cnt[CA_W-1:0];
                tbl_wdata  = {EPOCH_STALE, {WAVE_BITS{1'b0}}};
            end
            S_WR_A: begin
                mol_we  = r_ma_ok;
                cplx_we = r_ca_ok;
            end
            S_WR_B: begin
                // repeats harmlessly while the output is stalled
                mol_we     = r_mb_ok && !r_is_clear;
                cplx_we    = r_cb_ok && !r_is_clear;
                mol_waddr  = r_mb_addr;
                cplx_waddr = r_cb_addr;
            end
            default: begin
                mol_we  = 1'b0;
                cplx_we = 1'b0;
            end
        endcase
    end

    cfwa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MOLECULES)
    ) u_mol_ram (
        .i_clk    (i_clk),
        .i_we     (mol_we),
        .i_waddr  (mol_waddr),
        .i_wdata  (tbl_wdata),
        .i_raddr0 (mol_a_w[MA_W-1:0]),
        .i_raddr1 (mol_b_w[MA_W-1:0]),
        .o_rdata0 (mol_rd_a),
        .o_rdata1 (mol_rd_b)
    );

    cfwa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (COMPLEXES)
    ) u_cplx_ram (
        .i_clk    (i_clk),
        .i_we     (cplx_we),
        .i_waddr  (cplx_waddr),
        .i_wdata  (tbl_wdata),
        .i_raddr0 (cplx_a_w[CA_W-1:0]),
        .i_raddr1 (cplx_b_w[CA_W-1:0]),
        .o_rdata0 (cplx_rd_a),
        .o_rdata1 (cplx_rd_b)
    );

    // ---------------------------------------------------------------- wave max
    function automatic logic [WAVE_BITS-1:0] next_wave(input logic [WAVE_BITS-1:0] w);
        return (&w) ? w : w + 1'b1;
    endfunction

    function automatic logic [WAVE_BITS-1:0] term(
        input logic                   use_it,
        input logic [ENT_W-1:0]       ent,
        input logic [EPOCH_BITS-1:0]  epoch
    );
        logic hit;
        hit = use_it && (ent[ENT_W-1 -: EPOCH_BITS] == epoch);
        return hit ? next_wave(ent[WAVE_BITS-1:0]) : '0;
    endfunction

    logic [WAVE_BITS-1:0] t_ma, t_mb, t_ca, t_cb, t_ser, m0, m1, m2, wave_calc;

    always_comb begin
        t_ma  = term(r_ma_ok, mol_rd_a, r_epoch);
        t_mb  = term(r_mb_ok, mol_rd_b, r_epoch);
        t_ca  = term(r_ca_ok, cplx_rd_a, r_epoch);
        t_cb  = term(r_cb_ok, cplx_rd_b, r_epoch);
        t_ser = (r_unsafe && r_serial_valid) ? next_wave(r_serial_wave) : '0;
        m0 = (t_ma > t_mb) ? t_ma : t_mb;
        m1 = (t_ca > t_cb) ? t_ca : t_cb;
        m2 = (m0 > m1) ? m0 : m1;
        wave_calc = (m2 > t_ser) ? m2 : t_ser;
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_SWEEP;
            r_sweep_cnt    <= '0;
            r_epoch        <= EPOCH_FIRST;
            r_serial_valid <= 1'b0;
            r_out_valid    <= 1'b0;
            r_mol_count    <= COUNT_W'(4096);
            r_cplx_count   <= COUNT_W'(4096);
        end else begin
            // config writes are accepted in any state
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MOL_COUNT:  r_mol_count  <= i_cfg_data;
                    REG_CPLX_COUNT: r_cplx_count <= i_cfg_data;
                    default: ;
                endcase
            end

            // the write-back state refills the output register itself
            if (r_out_valid && !i_out_stall && (r_state != S_WR_B)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_SWEEP: begin
                    if (r_sweep_cnt == SW_W'(SWEEP_N - 1)) begin
                        r_sweep_cnt <= '0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_sweep_cnt <= r_sweep_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_is_clear <= (i_opcode == OP_CLEAR);
                        r_ma_ok    <= ma_ok;
                        r_mb_ok    <= mb_ok;
                        r_ca_ok    <= ca_ok;
                        r_cb_ok    <= cb_ok;
                        r_unsafe   <= unsafe && (i_opcode == OP_PAIR);
                        r_ma_addr  <= mol_a_w[MA_W-1:0];
                        r_mb_addr  <= mol_b_w[MA_W-1:0];
                        r_ca_addr  <= cplx_a_w[CA_W-1:0];
                        r_cb_addr  <= cplx_b_w[CA_W-1:0];
                        r_wave     <= '0;
                        if (i_opcode == OP_CLEAR) begin
                            r_state  <= S_WR_B;
                        end else begin
                            r_state  <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    // read data of the accepted beat is on the ram outputs now
                    r_wave  <= wave_calc;
                    r_state <= S_WR_A;
                end
                S_WR_A: begin
                    r_state <= S_WR_B;
                end
                S_WR_B: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_wave   <= r_wave;
                        r_out_serial <= r_unsafe;
                        if (r_is_clear) begin
                            r_serial_valid <= 1'b0;
                            if (r_epoch == EPOCH_LAST) begin
                                // tag wraps: scrub the tables first
                                r_epoch <= EPOCH_FIRST;
                                r_state <= S_SWEEP;
                            end else begin
                                r_epoch <= r_epoch + 1'b1;
                                r_state <= S_IDLE;
                            end
                        end else begin
                            if (r_unsafe) begin
                                r_serial_wave  <= r_wave;
                                r_serial_valid <= 1'b1;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_wave_number = r_out_wave;
    assign o_serialized  = r_out_serial;
    assign o_saturated   = &r_out_wave;

endmodule

// ===== sv/cfwa_checker.sv =====
// ----------------------------------------------------------------------------
// cfwa_checker
// port level checks of the wave assigner, bound to the core
// ----------------------------------------------------------------------------
module cfwa_checker
    import cfwa_pkg::*;
#(
    parameter int WAVE_BITS = WAVE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [WAVE_BITS-1:0]   o_wave_number,
    input logic                   o_serialized,
    input logic                   o_saturated
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_wave_number)
            && $stable(o_serialized) && $stable(o_saturated)))
        else $error("result beat changed while stalled");

    // saturation flag tracks the top wave value
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_saturated == (&o_wave_number)))
        else $error("saturated flag disagrees with wave number");

    // one beat in flight: input stalls right after an accept
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("beat accepted while previous beat in flight");

    // reset starts the table sweep with nothing pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_stall && !o_out_valid))
        else $error("input open or result pending after reset");

endmodule

bind conflict_free_wave_assigner_core cfwa_checker #(
    .WAVE_BITS (WAVE_BITS)
) u_cfwa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_wave_number (o_wave_number),
    .o_serialized  (o_serialized),
    .o_saturated   (o_saturated)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for conflict_free_wave_assigner_core: pair and clear
// beats go in, every result beat is compared field by field against a wave
// levelization predictor kept alongside the block
// ----------------------------------------------------------------------------
module tb;
    import cfwa_pkg::*;

    localparam int WAVE_MAX = (1 << WAVE_BITS_DEF) - 1;

    // one input beat as the block sees it
    typedef struct {
        logic                      op;
        logic [MOL_IDX_W-1:0]      mol_a;
        logic [MOL_IDX_W-1:0]      mol_b;
        logic signed [CPLX_W-1:0]  cplx_a;
        logic signed [CPLX_W-1:0]  cplx_b;
        logic [MFLAG_W-1:0]        mf_a;
        logic [MFLAG_W-1:0]        mf_b;
        logic [CFLAG_W-1:0]        cf_a;
        logic [CFLAG_W-1:0]        cf_b;
    } t_pair_beat;

    // one result beat
    typedef struct {
        logic [WAVE_BITS_DEF-1:0]  wave;
        logic                      serialized;
        logic                      saturated;
    } t_wave_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx = REG_MOL_COUNT;
    logic [COUNT_W-1:0]        i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic                      i_opcode = OP_CLEAR;
    logic [MOL_IDX_W-1:0]      i_mol_a = '0;
    logic [MOL_IDX_W-1:0]      i_mol_b = '0;
    logic signed [CPLX_W-1:0]  i_cplx_a = '0;
    logic signed [CPLX_W-1:0]  i_cplx_b = '0;
    logic [MFLAG_W-1:0]        i_mol_a_flags = '0;
    logic [MFLAG_W-1:0]        i_mol_b_flags = '0;
    logic [CFLAG_W-1:0]        i_cplx_a_flags = '0;
    logic [CFLAG_W-1:0]        i_cplx_b_flags = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [WAVE_BITS_DEF-1:0]  o_wave_number;
    logic                      o_serialized;
    logic                      o_saturated;

    // predictor state: last wave per molecule / complex, with batch valid bits
    logic [WAVE_BITS_DEF-1:0]  mol_wave  [MOLECULES_DEF];
    bit                        mol_seen  [MOLECULES_DEF];
    logic [WAVE_BITS_DEF-1:0]  cplx_wave [COMPLEXES_DEF];
    bit                        cplx_seen [COMPLEXES_DEF];
    logic [WAVE_BITS_DEF-1:0]  serial_wave = '0;
    bit                        serial_seen = 1'b0;
    logic [COUNT_W-1:0]        mol_limit = COUNT_W'(MOLECULES_DEF);
    logic [COUNT_W-1:0]        cplx_limit = COUNT_W'(COMPLEXES_DEF);

    t_wave_result              pending_waves [$];
    int                        mismatch_count = 0;

    // knobs for random idling on both sides, and a counted receiver hold-off
    bit                        tx_gaps = 1'b1;
    bit                        rx_gaps = 1'b1;
    int                        rx_hold_cycles = 0;

    conflict_free_wave_assigner_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_mol_a        (i_mol_a),
        .i_mol_b        (i_mol_b),
        .i_cplx_a       (i_cplx_a),
        .i_cplx_b       (i_cplx_b),
        .i_mol_a_flags  (i_mol_a_flags),
        .i_mol_b_flags  (i_mol_b_flags),
        .i_cplx_a_flags (i_cplx_a_flags),
        .i_cplx_b_flags (i_cplx_b_flags),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_wave_number  (o_wave_number),
        .o_serialized   (o_serialized),
        .o_saturated    (o_saturated)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // in-range complex: non-negative and below the programmed count
    function automatic bit cplx_in_range(logic signed [CPLX_W-1:0] c);
        return !c[CPLX_W-1] && ({1'b0, c[CPLX_W-2:0]} < cplx_limit);
    endfunction

    // wave of one beat; updates the tables the way the block does
    function automatic t_wave_result levelize(t_pair_beat b);
        t_wave_result r;
        bit ma_ok, mb_ok, ca_ok, cb_ok, unsafe, found;
        int top;
        int wave;
        logic [CPLX_W-2:0] ca, cb;

        r = '{'0, 1'b0, 1'b0};
        if (b.op == OP_CLEAR) begin
            // new batch: everything recorded so far goes stale
            mol_seen = '{default: 1'b0};
            cplx_seen = '{default: 1'b0};
            serial_seen = 1'b0;
            return r;
        end

        ma_ok = {1'b0, b.mol_a} < mol_limit;
        mb_ok = {1'b0, b.mol_b} < mol_limit;
        ca_ok = cplx_in_range(b.cplx_a);
        cb_ok = cplx_in_range(b.cplx_b);
        ca = b.cplx_a[CPLX_W-2:0];
        cb = b.cplx_b[CPLX_W-2:0];

        unsafe = !ma_ok || !mb_ok || !ca_ok || !cb_ok || (b.cplx_a == b.cplx_b);
        unsafe = unsafe || (|b.mf_a[MF_GHOST:MF_EMPTY]) || (|b.mf_b[MF_GHOST:MF_EMPTY]);
        unsafe = unsafe || (b.cf_a[CF_FIBER] && b.cf_b[CF_FIBER]);
        unsafe = unsafe || (b.cf_a[CF_SURFACE] && b.cf_b[CF_SURFACE]);
        unsafe = unsafe || (b.mf_a[MF_BONDS] && b.mf_a[MF_EXCL_VOL]);
        unsafe = unsafe || (b.mf_b[MF_BONDS] && b.mf_b[MF_EXCL_VOL]);

        // latest dependency among the live entries this pair touches
        found = 1'b0;
        top = 0;
        if (ma_ok && mol_seen[b.mol_a] && (!found || mol_wave[b.mol_a] > top)) begin
            top = mol_wave[b.mol_a];
            found = 1'b1;
        end
        if (mb_ok && mol_seen[b.mol_b] && (!found || mol_wave[b.mol_b] > top)) begin
            top = mol_wave[b.mol_b];
            found = 1'b1;
        end
        if (ca_ok && cplx_seen[ca] && (!found || cplx_wave[ca] > top)) begin
            top = cplx_wave[ca];
            found = 1'b1;
        end
        if (cb_ok && cplx_seen[cb] && (!found || cplx_wave[cb] > top)) begin
            top = cplx_wave[cb];
            found = 1'b1;
        end
        if (unsafe && serial_seen && (!found || serial_wave > top)) begin
            top = serial_wave;
            found = 1'b1;
        end
        // one past the latest dependency, held at the top wave
        wave = !found ? 0 : (top >= WAVE_MAX) ? WAVE_MAX : top + 1;

        if (ma_ok) begin
            mol_wave[b.mol_a] = wave[WAVE_BITS_DEF-1:0];
            mol_seen[b.mol_a] = 1'b1;
        end
        if (mb_ok) begin
            mol_wave[b.mol_b] = wave[WAVE_BITS_DEF-1:0];
            mol_seen[b.mol_b] = 1'b1;
        end
        if (ca_ok) begin
            cplx_wave[ca] = wave[WAVE_BITS_DEF-1:0];
            cplx_seen[ca] = 1'b1;
        end
        if (cb_ok) begin
            cplx_wave[cb] = wave[WAVE_BITS_DEF-1:0];
            cplx_seen[cb] = 1'b1;
        end
        if (unsafe) begin
            serial_wave = wave[WAVE_BITS_DEF-1:0];
            serial_seen = 1'b1;
        end

        r.wave = wave[WAVE_BITS_DEF-1:0];
        r.serialized = unsafe;
        r.saturated = (wave == WAVE_MAX);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result side: random stall, counted hold-off, and the checker
    // ------------------------------------------------------------------------

    // hold-off count is loaded at a falling edge, consumed here at rising edges
    always @(posedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            rx_hold_cycles--;
        end else begin
            i_out_stall <= rx_gaps && ($urandom_range(99) < 37);
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // outputs settle by the falling edge; a beat seen here moves on the next rise
    always @(negedge i_clk) begin
        t_wave_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_waves.size() == 0) begin
                $error("result beat with nothing outstanding: wave_number %0d",
                       o_wave_number);
                mismatch_count++;
            end else begin
                want = pending_waves.pop_front();
                check_field("wave_number", want.wave, o_wave_number);
                check_field("serialized", want.serialized, o_serialized);
                check_field("saturated", want.saturated, o_saturated);
            end
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // called at a rising edge, returns at the rising edge that takes the beat
    task automatic send_beat(t_pair_beat b);
        if (tx_gaps && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= b.op;
        i_mol_a        <= b.mol_a;
        i_mol_b        <= b.mol_b;
        i_cplx_a       <= b.cplx_a;
        i_cplx_b       <= b.cplx_b;
        i_mol_a_flags  <= b.mf_a;
        i_mol_b_flags  <= b.mf_b;
        i_cplx_a_flags <= b.cf_a;
        i_cplx_b_flags <= b.cf_b;
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        pending_waves = {pending_waves, levelize(b)};
        @(posedge i_clk);
    endtask

    // drop valid and let every outstanding result come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        wait (pending_waves.size() == 0);
        @(posedge i_clk);
    endtask

    // both counts, written back to back while the block is idle
    task automatic set_counts(int mols, int cplxs);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_MOL_COUNT;
        i_cfg_data <= COUNT_W'(mols);
        @(posedge i_clk);
        i_cfg_idx  <= REG_CPLX_COUNT;
        i_cfg_data <= COUNT_W'(cplxs);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        mol_limit  = COUNT_W'(mols);
        cplx_limit = COUNT_W'(cplxs);
    endtask

    function automatic t_pair_beat pair_of(logic op, int ma, int mb, int ca, int cb,
                                           int fa, int fb, int xa, int xb);
        t_pair_beat b;
        b.op     = op;
        b.mol_a  = MOL_IDX_W'(ma);
        b.mol_b  = MOL_IDX_W'(mb);
        b.cplx_a = CPLX_W'(ca);
        b.cplx_b = CPLX_W'(cb);
        b.mf_a   = MFLAG_W'(fa);
        b.mf_b   = MFLAG_W'(fb);
        b.cf_a   = CFLAG_W'(xa);
        b.cf_b   = CFLAG_W'(xb);
        return b;
    endfunction

    // mostly a small pool so pairs chain on each other, now and then anywhere
    function automatic int pick_mol(int pool);
        int r;
        r = $urandom_range(99);
        return (r < 85) ? $urandom_range(pool - 1) : $urandom_range(4095);
    endfunction

    // none, any negative, small pool or anywhere
    function automatic int pick_cplx(int pool);
        int r;
        r = $urandom_range(99);
        if (r < 10) return -1;
        if (r < 13) return $urandom_range(4096, 8191);
        if (r < 85) return $urandom_range(pool - 1);
        return $urandom_range(4095);
    endfunction

    // clean flags most of the time so safe pairs stay common
    function automatic int pick_mflags();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 80) return $urandom_range(31) & 5'b11000;
        return $urandom_range(31);
    endfunction

    function automatic t_pair_beat random_pair(int pool, int clear_pct);
        logic op;
        op = ($urandom_range(99) < clear_pct) ? OP_CLEAR : OP_PAIR;
        return pair_of(op, pick_mol(pool), pick_mol(pool), pick_cplx(pool),
                       pick_cplx(pool), pick_mflags(), pick_mflags(),
                       ($urandom_range(1) ? $urandom_range(3) : 0),
                       ($urandom_range(1) ? $urandom_range(3) : 0));
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // each flag and complex unsafe reason on its own, field extremes, and a clear between
    task automatic test_directed_cases();
        send_beat(pair_of(OP_PAIR, 0, 4095, 0, 4095, 0, 0, 0, 0));     // safe, first wave
        send_beat(pair_of(OP_PAIR, 0, 1, 1, 2, 0, 0, 0, 0));           // follows molecule 0
        send_beat(pair_of(OP_PAIR, 2, 3, -1, 5, 0, 0, 0, 0));          // no complex
        send_beat(pair_of(OP_PAIR, 4, 5, 6, 6, 0, 0, 0, 0));           // shared complex
        send_beat(pair_of(OP_PAIR, 6, 7, 8, 9, 1 << MF_EMPTY, 0, 0, 0));
        send_beat(pair_of(OP_PAIR, 8, 9, 10, 11, 0, 1 << MF_LIPID, 0, 0));
        send_beat(pair_of(OP_PAIR, 10, 11, 12, 13, 1 << MF_GHOST, 0, 0, 0));
        send_beat(pair_of(OP_PAIR, 12, 13, 14, 15, 0, 0, 1 << CF_FIBER, 1 << CF_FIBER));
        send_beat(pair_of(OP_PAIR, 14, 15, 16, 17, 0, 0,
                          1 << CF_SURFACE, 1 << CF_SURFACE));
        send_beat(pair_of(OP_PAIR, 16, 17, 18, 19, 0, 0, 1 << CF_FIBER, 1 << CF_SURFACE));
        send_beat(pair_of(OP_PAIR, 18, 19, 20, 21, 1 << MF_BONDS, 1 << MF_EXCL_VOL, 0, 0));
        send_beat(pair_of(OP_PAIR, 20, 21, 22, 23,
                          (1 << MF_BONDS) | (1 << MF_EXCL_VOL), 0, 0, 0));
        send_beat(pair_of(OP_PAIR, 22, 23, 24, 25, 0,
                          (1 << MF_BONDS) | (1 << MF_EXCL_VOL), 0, 0));
        send_beat(pair_of(OP_PAIR, 4095, 4095, 4095, 4095, 31, 31, 3, 3));
        send_beat(pair_of(OP_PAIR, 0, 3, -4096, 1, 0, 0, 0, 0));      // most negative
        send_beat(pair_of(OP_CLEAR, 4095, 4095, -1, -1, 31, 31, 3, 3));
        send_beat(pair_of(OP_PAIR, 0, 4095, 0, 4095, 0, 0, 0, 0));     // stale after clear
        send_beat(pair_of(OP_PAIR, 2, 3, -1, 5, 1 << MF_EMPTY, 0, 0, 0));
        send_beat(pair_of(OP_PAIR, 0, 2, 1, 5, 0, 0, 0, 0));
        wait_idle();
    endtask

    // counts at zero, above range, and one, then back to the default
    task automatic test_count_limits();
        set_counts(0, 0);
        send_beat(pair_of(OP_PAIR, 0, 1, 0, 1, 0, 0, 0, 0));
        send_beat(pair_of(OP_PAIR, 0, 1, 0, 1, 0, 0, 0, 0));
        wait_idle();
        set_counts(8191, 8191);
        send_beat(pair_of(OP_PAIR, 4095, 4094, 4095, 4094, 0, 0, 0, 0));
        send_beat(pair_of(OP_PAIR, 4095, 0, 4094, 1, 0, 0, 0, 0));
        wait_idle();
        set_counts(1, 1);
        send_beat(pair_of(OP_PAIR, 0, 1, 0, 1, 0, 0, 0, 0));           // b side out of range
        send_beat(pair_of(OP_PAIR, 0, 0, 0, 0, 0, 0, 0, 0));
        wait_idle();
        set_counts(MOLECULES_DEF, COMPLEXES_DEF);
    endtask

    // receiver holds off long enough to back the block up into the sender,
    // then the sender stops until everything is home, and a gapped run follows
    task automatic test_backpressure();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        @(negedge i_clk);
        rx_hold_cycles = 250;
        @(posedge i_clk);
        repeat (40) send_beat(random_pair(8, 5));
        wait_idle();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        repeat (20) send_beat(random_pair(8, 5));
        wait_idle();
    endtask

    // enough batches to wrap the batch tag; stale entries must stay invisible
    task automatic test_batch_turnover();
        for (int n = 0; n < 260; n++) begin
            send_beat(random_pair(4096, 100));
            send_beat(pair_of(OP_PAIR, 7, 8, 9, 10, 0, 0, 0, 0));
            if (n % 4 == 0) send_beat(pair_of(OP_PAIR, 7, 11, 12, 13, 0, 0, 0, 0));
        end
        wait_idle();
    endtask

    // random pairs under several count settings; one phase runs without gaps
    task automatic test_random_mix();
        int mol_set[5];
        int cplx_set[5];
        int pool_set[5];
        mol_set  = '{4096, 12, 8191, 0, 4096};
        cplx_set = '{4096, 10, 8191, 4096, 0};
        pool_set = '{16, 16, 64, 8, 8};
        for (int p = 0; p < 5; p++) begin
            set_counts(mol_set[p], cplx_set[p]);
            tx_gaps = (p != 2);
            rx_gaps = (p != 2);
            repeat (90) send_beat(random_pair(pool_set[p], 4));
            wait_idle();
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        set_counts(MOLECULES_DEF, COMPLEXES_DEF);
    endtask

    // one unbroken chain on the same molecules climbs a wave per beat,
    // then unsafe pairs keep stacking on top of it
    task automatic test_long_chain();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        send_beat(pair_of(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        repeat (30) send_beat(pair_of(OP_PAIR, 5, 6, 7, 8, 0, 0, 0, 0));
        repeat (4) send_beat(pair_of(OP_PAIR, 5, 6, 7, 8, 1 << MF_EMPTY, 0, 0, 0));
        wait_idle();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_count_limits();
        test_backpressure();
        test_batch_turnover();
        test_random_mix();
        test_long_chain();
        wait_idle();
        // a little slack for anything the block should not be sending
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("conflict_free_wave_assigner_core: match");
        end else begin
            $display("conflict_free_wave_assigner_core: mismatch");
        end
        $finish;
    end

    // guard against a hang; a correct run takes well under a quarter of this
    initial begin
        #6_000_000;
        $display("conflict_free_wave_assigner_core: mismatch");
        $finish;
    end

endmodule
